>>> rtl/iwsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwsr_pkg
// Shared constants and types of the I2C write-only slave receiver.
// ----------------------------------------------------------------------------
package iwsr_pkg;

  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned COUNT_W = 4;

  localparam logic [ADDR_W-1:0]  ADDR_RESET = 7'h42;
  localparam logic [COUNT_W-1:0] BYTE_BITS  = 4'd8;

  localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ADDR      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ADDR_ACK  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DATA      = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA_ACK  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_WAIT_STOP = 3'd5;

  typedef struct packed {
    logic              sda_pull_low;
    logic [BYTE_W-1:0] dac_value;
    logic              dac_strobe;
  } result_t;

endpackage : iwsr_pkg
`default_nettype wire

>>> rtl/iwsr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwsr_if
// Valid/ready channels: bus line samples in, receiver results out.
// ----------------------------------------------------------------------------
interface iwsr_in_if;
  logic valid;
  logic ready;
  logic scl_level;
  logic sda_level;

  modport source (output valid, output scl_level, output sda_level, input ready);
  modport sink   (input valid, input scl_level, input sda_level, output ready);
endinterface : iwsr_in_if

interface iwsr_out_if;
  logic       valid;
  logic       ready;
  logic       sda_pull_low;
  logic [7:0] dac_value;
  logic       dac_strobe;

  modport source (output valid, output sda_pull_low, output dac_value,
                  output dac_strobe, input ready);
  modport sink   (input valid, input sda_pull_low, input dac_value,
                  input dac_strobe, output ready);
endinterface : iwsr_out_if
`default_nettype wire

>>> rtl/iwsr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iwsr_core
// Bus phase machine: START/STOP detection, bit shifting, address match, ACK.
// ----------------------------------------------------------------------------
module iwsr_core
  import iwsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire logic              step,
  input  wire logic              scl,
  input  wire logic              sda,
  output result_t                result
);

  logic [ADDR_W-1:0]  slave_addr_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic               prev_scl_r, prev_sda_r;
  logic               ack_r, ack_nxt;
  logic [BYTE_W-1:0]  dac_r, dac_nxt;
  logic               strobe;
  logic               rise, fall, match;

  assign rise  = !prev_scl_r && scl;
  assign fall  = prev_scl_r && !scl;
  assign match = (shift_r[BYTE_W-1:1] == slave_addr_r) && !shift_r[0];

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    shift_nxt = shift_r;
    ack_nxt   = ack_r;
    dac_nxt   = dac_r;
    strobe    = 1'b0;
    case (phase_r)
      PH_ADDR, PH_DATA: begin
        if (rise && (count_r < BYTE_BITS)) begin
          shift_nxt = {shift_r[BYTE_W-2:0], sda};
          count_nxt = count_r + 4'd1;
        end else if (fall && (count_r >= BYTE_BITS)) begin
          count_nxt = '0;
          if (phase_r == PH_ADDR) begin
            ack_nxt   = match;
            phase_nxt = PH_ADDR_ACK;
          end else begin
            ack_nxt   = 1'b1;
            phase_nxt = PH_DATA_ACK;
          end
        end
      end
      PH_ADDR_ACK, PH_DATA_ACK: begin
        if (rise) begin
          count_nxt = 4'd1;
        end else if (fall && (count_r != '0)) begin
          count_nxt = '0;
          if (phase_r == PH_ADDR_ACK) begin
            phase_nxt = ack_r ? PH_DATA : PH_WAIT_STOP;
            shift_nxt = '0;
          end else begin
            dac_nxt   = shift_r;
            strobe    = 1'b1;
            phase_nxt = PH_WAIT_STOP;
          end
          ack_nxt = 1'b0;
        end
      end
      PH_WAIT_STOP: begin
        if (scl && !prev_sda_r && sda) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        ack_nxt   = 1'b0;
        count_nxt = '0;
        if (scl && prev_sda_r && !sda) begin
          phase_nxt = PH_ADDR;
          shift_nxt = '0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  assign result.sda_pull_low = ack_nxt;
  assign result.dac_value    = dac_nxt;
  assign result.dac_strobe   = strobe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= ADDR_RESET;
      phase_r      <= PH_IDLE;
      count_r      <= '0;
      shift_r      <= '0;
      prev_scl_r   <= 1'b1;
      prev_sda_r   <= 1'b1;
      ack_r        <= 1'b0;
      dac_r        <= '0;
    end else begin
      if (cfg_we) begin
        slave_addr_r <= cfg_wdata;
      end
      if (step) begin
        phase_r    <= phase_nxt;
        count_r    <= count_nxt;
        shift_r    <= shift_nxt;
        prev_scl_r <= scl;
        prev_sda_r <= sda;
        ack_r      <= ack_nxt;
        dac_r      <= dac_nxt;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= BYTE_BITS)
    else $error("bit count beyond one byte");

  a_ack_only_in_ack: assert property (@(posedge clk) disable iff (!rst_n)
    ack_r |-> (phase_r == PH_ADDR_ACK || phase_r == PH_DATA_ACK))
    else $error("SDA pulled low outside an ACK clock");

  a_strobe_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (step && strobe) |=> (dac_r == $past(shift_r) && phase_r == PH_WAIT_STOP))
    else $error("DAC byte not loaded on strobe");

endmodule : iwsr_core
`default_nettype wire

>>> rtl/i2c_write_slave_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_write_slave_receiver
// I2C write-only slave that ACKs its address and latches one data byte.
// ----------------------------------------------------------------------------
// Takes one SCL/SDA sample transaction per clock while the result side does
// not stall, a sustained rate set by the per-sample phase state update, and
// returns one result transaction per sample: the sample passes an input
// register, then the phase machine, then the result register. The result
// register frees as it is taken, so a stall on the result side holds at most
// one sample in each register. The user must write the slave address through
// cfg_we/cfg_wdata only while no transaction is open; no logic enforces it.
// ----------------------------------------------------------------------------
module i2c_write_slave_receiver
  import iwsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  iwsr_in_if.sink                in_bus,
  iwsr_out_if.source             out_res
);

  logic    s1_valid_r;
  logic    s1_scl_r, s1_sda_r;
  logic    out_valid_r;
  result_t out_r;
  result_t core_result;
  logic    out_free, step, in_take;

  assign out_free     = !out_valid_r || out_res.ready;
  assign step         = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || out_free;
  assign in_take      = in_bus.valid && in_bus.ready;

  iwsr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .scl       (s1_scl_r),
    .sda       (s1_sda_r),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_scl_r <= in_bus.scl_level;
      s1_sda_r <= in_bus.sda_level;
    end
    if (step) begin
      out_r <= core_result;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.sda_pull_low = out_r.sda_pull_low;
  assign out_res.dac_value    = out_r.dac_value;
  assign out_res.dac_strobe   = out_r.dac_strobe;

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("result lost after phase update");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (s1_valid_r && out_valid_r && !out_res.ready))
    else $error("input stalled with room downstream");

  a_strobe_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.dac_strobe) |-> !out_r.sda_pull_low)
    else $error("SDA held low on DAC strobe");

endmodule : i2c_write_slave_receiver
`default_nettype wire
